>>> hw/rtl/dtl_pkg.sv
package dtl_pkg;

   localparam int INPUTS   = 16;
   localparam int NEURONS  = 16;
   localparam int ELEM_W   = 4;
   localparam int NRN_W    = 4;
   localparam int ADDR_W   = NRN_W + ELEM_W;
   localparam int DATA_W   = 16;
   localparam int ACT_W    = 14;
   localparam int ACC_W    = 40;
   localparam int PROD_W   = 33;
   localparam int LE_W     = 17;
   localparam int ROM_HALF = 2048;
   localparam int EXP_LIMIT = 1280;
   localparam logic [15:0] LEARN_RATE_RESET = 16'd655;

   typedef enum logic [1:0] {
      OP_LOAD_WEIGHT = 2'd0,
      OP_LOAD_BIAS   = 2'd1,
      OP_INPUT_ELEM  = 2'd2,
      OP_TARGET      = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FWD_INIT,
      ST_FWD_MAC,
      ST_FWD_DRAIN1,
      ST_FWD_DRAIN2,
      ST_FWD_ROM,
      ST_FWD_OUT,
      ST_UPD_ERR,
      ST_UPD_LE,
      ST_UPD_MAC,
      ST_UPD_DRAIN1,
      ST_UPD_DRAIN2,
      ST_UPD_BIAS
   } state_type;

   typedef struct packed {
      logic              acc_init;
      logic              mac_issue;
      logic              upd_mode;
      logic              rom_load;
      logic              out_emit;
      logic              out_last;
      logic              err_calc;
      logic              le_calc;
      logic              bias_upd;
      logic [NRN_W-1:0]  nrn_idx;
      logic [ELEM_W-1:0] elem_idx;
   } cmd_type;

   typedef logic [12:0] tanh_tab_type [0:ROM_HALF];

   function automatic logic [63:0] mul_shr62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62] + {63'd0, p[61]};
   endfunction

   function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], a[i]};
         if (rem >= {1'b0, b}) begin
            rem    = rem - {1'b0, b};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic tanh_tab_type build_tanh();
      tanh_tab_type tab;
      logic [63:0]  term;
      logic [63:0]  c;
      logic [63:0]  e48;
      logic [63:0]  e34;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [63:0]  q;
      term = 64'd1 << 62;
      c    = 64'd0;
      e48  = 64'd1 << 48;
      for (int n = 1; n < 40; n++) begin
         if (term != 64'd0) begin
            c    = c + term;
            term = udiv64(term >> 7, 64'(n));
         end
      end
      for (int k = 0; k <= ROM_HALF; k++) begin
         if (k < EXP_LIMIT) begin
            e34 = (e48 + (64'd1 << 13)) >> 14;
            num = e34 - (64'd1 << 34);
            den = e34 + (64'd1 << 34);
            q   = udiv64(num * 64'd8192 + den, den * 64'd2);
            tab[k] = q[12:0];
            e48 = mul_shr62(e48, c);
         end else begin
            tab[k] = 13'd4096;
         end
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh();

endpackage

>>> hw/rtl/dtl_ctrl.sv
module dtl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_op,
   input  logic [dtl_pkg::NRN_W-1:0] req_neuron_sel,
   input  logic                      req_last_elem,
   output logic                      busy,
   output dtl_pkg::cmd_type          cmd
);

   dtl_pkg::state_type state_ff, state_in;
   logic [dtl_pkg::NRN_W-1:0]  nrn_ff, nrn_in;
   logic [dtl_pkg::ELEM_W-1:0] elem_ff, elem_in;
   logic accept;
   logic elem_end;
   logic nrn_end;

   assign accept   = start && (state_ff == dtl_pkg::ST_IDLE);
   assign elem_end = (elem_ff == dtl_pkg::ELEM_W'(dtl_pkg::INPUTS - 1));
   assign nrn_end  = (nrn_ff == dtl_pkg::NRN_W'(dtl_pkg::NEURONS - 1));
   assign busy     = (state_ff != dtl_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtl_pkg::ST_IDLE;
         nrn_ff   <= '0;
         elem_ff  <= '0;
      end else begin
         state_ff <= state_in;
         nrn_ff   <= nrn_in;
         elem_ff  <= elem_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      nrn_in   = nrn_ff;
      elem_in  = elem_ff;
      unique case (state_ff)
         dtl_pkg::ST_IDLE: begin
            elem_in = '0;
            if (accept && req_op == dtl_pkg::OP_INPUT_ELEM && req_last_elem) begin
               nrn_in   = '0;
               state_in = dtl_pkg::ST_FWD_INIT;
            end else if (accept && req_op == dtl_pkg::OP_TARGET &&
                         {1'b0, req_neuron_sel} < (dtl_pkg::NRN_W + 1)'(dtl_pkg::NEURONS)) begin
               nrn_in   = req_neuron_sel;
               state_in = dtl_pkg::ST_UPD_ERR;
            end
         end
         dtl_pkg::ST_FWD_INIT: begin
            elem_in  = '0;
            state_in = dtl_pkg::ST_FWD_MAC;
         end
         dtl_pkg::ST_FWD_MAC: begin
            elem_in = elem_ff + 1'b1;
            if (elem_end) state_in = dtl_pkg::ST_FWD_DRAIN1;
         end
         dtl_pkg::ST_FWD_DRAIN1: state_in = dtl_pkg::ST_FWD_DRAIN2;
         dtl_pkg::ST_FWD_DRAIN2: state_in = dtl_pkg::ST_FWD_ROM;
         dtl_pkg::ST_FWD_ROM:    state_in = dtl_pkg::ST_FWD_OUT;
         dtl_pkg::ST_FWD_OUT: begin
            if (nrn_end) begin
               state_in = dtl_pkg::ST_IDLE;
            end else begin
               nrn_in   = nrn_ff + 1'b1;
               state_in = dtl_pkg::ST_FWD_INIT;
            end
         end
         dtl_pkg::ST_UPD_ERR: state_in = dtl_pkg::ST_UPD_LE;
         dtl_pkg::ST_UPD_LE: begin
            elem_in  = '0;
            state_in = dtl_pkg::ST_UPD_MAC;
         end
         dtl_pkg::ST_UPD_MAC: begin
            elem_in = elem_ff + 1'b1;
            if (elem_end) state_in = dtl_pkg::ST_UPD_DRAIN1;
         end
         dtl_pkg::ST_UPD_DRAIN1: state_in = dtl_pkg::ST_UPD_DRAIN2;
         dtl_pkg::ST_UPD_DRAIN2: state_in = dtl_pkg::ST_UPD_BIAS;
         dtl_pkg::ST_UPD_BIAS:   state_in = dtl_pkg::ST_IDLE;
         default:                state_in = dtl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.nrn_idx  = nrn_ff;
      cmd.elem_idx = elem_ff;
      unique case (state_ff)
         dtl_pkg::ST_FWD_INIT: cmd.acc_init  = 1'b1;
         dtl_pkg::ST_FWD_MAC:  cmd.mac_issue = 1'b1;
         dtl_pkg::ST_FWD_ROM:  cmd.rom_load  = 1'b1;
         dtl_pkg::ST_FWD_OUT: begin
            cmd.out_emit = 1'b1;
            cmd.out_last = nrn_end;
         end
         dtl_pkg::ST_UPD_ERR: begin
            cmd.upd_mode = 1'b1;
            cmd.err_calc = 1'b1;
         end
         dtl_pkg::ST_UPD_LE: begin
            cmd.upd_mode = 1'b1;
            cmd.le_calc  = 1'b1;
         end
         dtl_pkg::ST_UPD_MAC: begin
            cmd.upd_mode  = 1'b1;
            cmd.mac_issue = 1'b1;
         end
         dtl_pkg::ST_UPD_DRAIN1, dtl_pkg::ST_UPD_DRAIN2: cmd.upd_mode = 1'b1;
         dtl_pkg::ST_UPD_BIAS: begin
            cmd.upd_mode = 1'b1;
            cmd.bias_upd = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

>>> hw/rtl/dtl_datapath.sv
module dtl_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [1:0]                         req_op,
   input  logic [dtl_pkg::NRN_W-1:0]          req_neuron_sel,
   input  logic [dtl_pkg::ELEM_W-1:0]         req_elem_index,
   input  logic signed [dtl_pkg::DATA_W-1:0]  req_value,
   input  logic                               csr_we,
   input  logic [15:0]                        csr_wdata,
   input  dtl_pkg::cmd_type                   cmd,
   output logic                               rsp_valid,
   output logic [dtl_pkg::NRN_W-1:0]          rsp_neuron_id,
   output logic signed [dtl_pkg::ACT_W-1:0]   rsp_activation,
   output logic                               rsp_last_out
);

   localparam int DW = dtl_pkg::DATA_W;

   logic [DW-1:0] weight_mem [0:dtl_pkg::NEURONS*dtl_pkg::INPUTS-1];
   logic signed [DW-1:0] bias_ff   [0:dtl_pkg::NEURONS-1];
   logic signed [DW-1:0] input_ff  [0:dtl_pkg::INPUTS-1];
   logic signed [DW-1:0] output_ff [0:dtl_pkg::NEURONS-1];

   logic [15:0] lr_ff;
   logic signed [DW-1:0] target_ff;

   logic signed [DW-1:0]          w1_ff, x1_ff, w2_ff;
   logic [dtl_pkg::ADDR_W-1:0]    a1_ff, a2_ff;
   logic                          v1_ff, v2_ff;
   logic signed [dtl_pkg::PROD_W-1:0] prod_ff;
   logic signed [dtl_pkg::ACC_W-1:0]  acc_ff;
   logic signed [33:0]            err_prod_ff;
   logic signed [dtl_pkg::LE_W-1:0] le_ff;
   logic signed [dtl_pkg::ACT_W-1:0] act_ff;

   logic signed [16:0] err;
   logic signed [16:0] mul_a;
   logic signed [20:0] dw;
   logic signed [21:0] w_sum;
   logic [DW-1:0]      w_new;
   logic signed [17:0] b_sum;
   logic [DW-1:0]      b_new;
   logic signed [23:0] q;
   logic [11:0]        q_mag;
   logic [12:0]        tab_val;
   logic [dtl_pkg::ADDR_W-1:0] load_addr;
   logic [dtl_pkg::ADDR_W-1:0] issue_addr;

   function automatic logic [15:0] sat16(logic signed [21:0] v);
      if (v > 22'sd32767)  return 16'h7FFF;
      if (v < -22'sd32768) return 16'h8000;
      return v[15:0];
   endfunction

   assign load_addr  = {req_neuron_sel, req_elem_index};
   assign issue_addr = {cmd.nrn_idx, cmd.elem_idx};
   assign err   = 17'(target_ff) - 17'(output_ff[cmd.nrn_idx]);
   assign mul_a = cmd.upd_mode ? le_ff : 17'(w1_ff);
   assign dw    = prod_ff[32:12];
   assign w_sum = 22'(w2_ff) + 22'(dw);
   assign w_new = sat16(w_sum);
   assign b_sum = 18'(bias_ff[cmd.nrn_idx]) + 18'(le_ff);
   assign b_new = sat16(22'(b_sum));

   always_comb begin
      q = acc_ff[39:16];
      if (q > 24'sd2047) q = 24'sd2047;
      if (q < -24'sd2048) q = -24'sd2048;
      q_mag   = q[23] ? 12'(-q) : q[11:0];
      tab_val = dtl_pkg::TANH_TAB[q_mag];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= dtl_pkg::LEARN_RATE_RESET;
      end else if (csr_we) begin
         lr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_op == dtl_pkg::OP_LOAD_WEIGHT) begin
         weight_mem[load_addr] <= req_value;
      end else if (v2_ff && cmd.upd_mode) begin
         weight_mem[a2_ff] <= w_new;
      end
      w1_ff <= weight_mem[issue_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_op == dtl_pkg::OP_LOAD_BIAS) begin
         bias_ff[req_neuron_sel] <= req_value;
      end else if (cmd.bias_upd) begin
         bias_ff[cmd.nrn_idx] <= b_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dtl_pkg::INPUTS; i++) input_ff[i] <= '0;
         for (int i = 0; i < dtl_pkg::NEURONS; i++) output_ff[i] <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (accept && req_op == dtl_pkg::OP_INPUT_ELEM) begin
            input_ff[req_elem_index] <= req_value;
         end
         if (cmd.out_emit) begin
            output_ff[cmd.nrn_idx] <= DW'(act_ff);
         end
         v1_ff     <= cmd.mac_issue;
         v2_ff     <= v1_ff;
         rsp_valid <= cmd.rom_load;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) target_ff <= req_value;
      x1_ff   <= input_ff[cmd.elem_idx];
      a1_ff   <= issue_addr;
      a2_ff   <= a1_ff;
      w2_ff   <= w1_ff;
      prod_ff <= mul_a * 33'(x1_ff);
      if (cmd.err_calc) err_prod_ff <= $signed({18'd0, lr_ff}) * 34'(err);
      if (cmd.le_calc)  le_ff <= err_prod_ff[32:16];
      if (cmd.acc_init) begin
         acc_ff <= 40'(bias_ff[cmd.nrn_idx]) <<< 12;
      end else if (v2_ff && !cmd.upd_mode) begin
         acc_ff <= acc_ff + 40'(prod_ff);
      end
      if (cmd.rom_load) begin
         act_ff         <= q[23] ? -$signed({1'b0, tab_val}) : $signed({1'b0, tab_val});
         rsp_neuron_id  <= cmd.nrn_idx;
         rsp_last_out   <= (cmd.nrn_idx == dtl_pkg::NRN_W'(dtl_pkg::NEURONS - 1));
      end
   end

   assign rsp_activation = act_ff;

endmodule

>>> hw/rtl/dense_tanh_layer_with_delta_update_top.sv
// channel   ports                                          handshake
// request   req_op req_neuron_sel req_elem_index req_value  start, busy
//           req_last_elem
// response  rsp_neuron_id rsp_activation rsp_last_out      rsp_valid, one cycle
// csr       csr_wdata                                       csr_we
//
// Load and unmarked input beats are taken while idle and do not raise busy.
// A last input beat runs all 16 neurons in turn: per neuron one MAC per input through one
// multiplier and the weight RAM read port, plus init, drain, ROM and output states.
// A target beat runs error, rate product, 16 weight writes, drain and bias steps.
// Reset is synchronous and clears control, the input vector and the output vector.
// Responses leave at one per neuron; the receiver cannot stall them.
module dense_tanh_layer_with_delta_update_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_op,
   input  logic [dtl_pkg::NRN_W-1:0]          req_neuron_sel,
   input  logic [dtl_pkg::ELEM_W-1:0]         req_elem_index,
   input  logic signed [dtl_pkg::DATA_W-1:0]  req_value,
   input  logic                               req_last_elem,
   output logic                               rsp_valid,
   output logic [dtl_pkg::NRN_W-1:0]          rsp_neuron_id,
   output logic signed [dtl_pkg::ACT_W-1:0]   rsp_activation,
   output logic                               rsp_last_out,
   input  logic                               csr_we,
   input  logic [15:0]                        csr_wdata
);

   dtl_pkg::cmd_type cmd;
   logic accept;

   assign accept = start && !busy;

   dtl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_op         (req_op),
      .req_neuron_sel (req_neuron_sel),
      .req_last_elem  (req_last_elem),
      .busy           (busy),
      .cmd            (cmd)
   );

   dtl_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_op         (req_op),
      .req_neuron_sel (req_neuron_sel),
      .req_elem_index (req_elem_index),
      .req_value      (req_value),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_neuron_id  (rsp_neuron_id),
      .rsp_activation (rsp_activation),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

>>> hw/rtl/dtl_checker.sv
module dtl_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic [1:0] req_op,
   input logic req_last_elem,
   input logic rsp_valid,
   input logic rsp_last_out
);

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response beat outside busy");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back response beats");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_out) |=> !busy) else $error("busy after final beat");

   a_fwd_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == dtl_pkg::OP_INPUT_ELEM && req_last_elem) |=> busy)
      else $error("forward pass did not start");

endmodule

bind dense_tanh_layer_with_delta_update_top dtl_checker u_dtl_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_op        (req_op),
   .req_last_elem (req_last_elem),
   .rsp_valid     (rsp_valid),
   .rsp_last_out  (rsp_last_out)
);

>>> bench/dense_tanh_layer_with_delta_update_top_tb.sv
`timescale 1ns / 100ps

module dense_tanh_layer_with_delta_update_top_tb;

   typedef struct {
      logic [dtl_pkg::NRN_W-1:0]         id;
      logic signed [dtl_pkg::ACT_W-1:0]  act;
      logic                              last;
   } activation_beat_type;

   class layer_scoreboard_type;
      logic signed [dtl_pkg::DATA_W-1:0] weight_mem [dtl_pkg::NEURONS*dtl_pkg::INPUTS];
      logic signed [dtl_pkg::DATA_W-1:0] bias_mem [dtl_pkg::NEURONS];
      logic signed [dtl_pkg::DATA_W-1:0] in_vec [dtl_pkg::INPUTS];
      logic signed [dtl_pkg::DATA_W-1:0] out_vec [dtl_pkg::NEURONS];
      logic [15:0]              rate;
      longint                   tanh_rom [dtl_pkg::ROM_HALF+1];
      activation_beat_type      act_q [$];
      int                       errors;

      function new();
         longint unsigned term, c, e48, e34, num, den, n;
         logic [127:0]    p;
         term = 64'd1 << 62;
         c = 0;
         n = 1;
         e48 = 64'd1 << 48;
         while (term != 0) begin
            c = c + term;
            term = (term >> 7) / n;
            n++;
         end
         for (int k = 0; k <= dtl_pkg::ROM_HALF; k++) begin
            if (k < dtl_pkg::EXP_LIMIT) begin
               e34 = (e48 + (64'd1 << 13)) >> 14;
               num = e34 - (64'd1 << 34);
               den = e34 + (64'd1 << 34);
               tanh_rom[k] = (num * 8192 + den) / (den * 2);
               p = {64'd0, e48} * {64'd0, c};
               e48 = p[125:62] + 64'(p[61]);
            end else begin
               tanh_rom[k] = 4096;
            end
         end
         rate = dtl_pkg::LEARN_RATE_RESET;
         errors = 0;
         foreach (in_vec[i]) in_vec[i] = 0;
         foreach (out_vec[i]) out_vec[i] = 0;
      endfunction

      function logic signed [dtl_pkg::DATA_W-1:0] sat16(longint v);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return -16'sh8000;
         return v[15:0];
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      function void note(dtl_pkg::op_type op, int n, int e, logic signed [15:0] v,
                         logic last);
         longint acc, q, err, le;
         activation_beat_type b;
         case (op)
            dtl_pkg::OP_LOAD_WEIGHT: weight_mem[n*dtl_pkg::INPUTS+e] = v;
            dtl_pkg::OP_LOAD_BIAS:   bias_mem[n] = v;
            dtl_pkg::OP_INPUT_ELEM: begin
               in_vec[e] = v;
               if (last) begin
                  for (int k = 0; k < dtl_pkg::NEURONS; k++) begin
                     acc = longint'(bias_mem[k]) * 4096;
                     for (int i = 0; i < dtl_pkg::INPUTS; i++)
                        acc += longint'(weight_mem[k*dtl_pkg::INPUTS+i])
                               * longint'(in_vec[i]);
                     q = acc >>> 16;
                     if (q > dtl_pkg::ROM_HALF - 1) q = dtl_pkg::ROM_HALF - 1;
                     if (q < -dtl_pkg::ROM_HALF) q = -dtl_pkg::ROM_HALF;
                     out_vec[k] = dtl_pkg::DATA_W'((q >= 0) ? tanh_rom[q] : -tanh_rom[-q]);
                     b.id = dtl_pkg::NRN_W'(k);
                     b.act = dtl_pkg::ACT_W'(out_vec[k]);
                     b.last = (k == dtl_pkg::NEURONS - 1);
                     act_q.push_back(b);
                  end
               end
            end
            dtl_pkg::OP_TARGET: begin
               err = longint'(v) - longint'(out_vec[n]);
               le = (longint'(rate) * err) >>> 16;
               for (int i = 0; i < dtl_pkg::INPUTS; i++)
                  weight_mem[n*dtl_pkg::INPUTS+i] =
                     sat16(longint'(weight_mem[n*dtl_pkg::INPUTS+i])
                           + ((le * longint'(in_vec[i])) >>> 12));
               bias_mem[n] = sat16(longint'(bias_mem[n]) + le);
            end
         endcase
      endfunction

      task check(logic [dtl_pkg::NRN_W-1:0] id, logic signed [dtl_pkg::ACT_W-1:0] act,
                 logic last);
         activation_beat_type b;
         if (act_q.size() == 0) begin
            report($sformatf("unexpected beat neuron %0d", id));
         end else begin
            b = act_q.pop_front();
            if (id !== b.id)
               report($sformatf("neuron_id %0d, want %0d", id, b.id));
            if (act !== b.act)
               report($sformatf("neuron %0d activation %0d, want %0d", b.id, act, b.act));
            if (last !== b.last)
               report($sformatf("neuron %0d last_out %0b, want %0b", b.id, last, b.last));
         end
      endtask
   endclass

   localparam int CYCLE_LIMIT = 400000;

   logic                              clock = 0;
   logic                              reset = 1;
   logic                              start = 0;
   logic                              busy;
   logic [1:0]                        req_op = 0;
   logic [dtl_pkg::NRN_W-1:0]         req_neuron_sel = 0;
   logic [dtl_pkg::ELEM_W-1:0]        req_elem_index = 0;
   logic signed [dtl_pkg::DATA_W-1:0] req_value = 0;
   logic                              req_last_elem = 0;
   logic                              rsp_valid;
   logic [dtl_pkg::NRN_W-1:0]         rsp_neuron_id;
   logic signed [dtl_pkg::ACT_W-1:0]  rsp_activation;
   logic                              rsp_last_out;
   logic                              csr_we = 0;
   logic [15:0]                       csr_wdata = 0;

   layer_scoreboard_type sb = new();
   int cycles = 0;

   dense_tanh_layer_with_delta_update_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_neuron_sel(req_neuron_sel), .req_elem_index(req_elem_index),
      .req_value(req_value), .req_last_elem(req_last_elem),
      .rsp_valid(rsp_valid), .rsp_neuron_id(rsp_neuron_id),
      .rsp_activation(rsp_activation), .rsp_last_out(rsp_last_out),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check(rsp_neuron_id, rsp_activation, rsp_last_out);
   end

   task send(dtl_pkg::op_type op, int n, int e, logic signed [15:0] v, logic last);
      @(negedge clock);
      start <= 1;
      req_op <= op;
      req_neuron_sel <= dtl_pkg::NRN_W'(n);
      req_elem_index <= dtl_pkg::ELEM_W'(e);
      req_value <= v;
      req_last_elem <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note(op, n, e, v, last);
   endtask

   task hold_off(int gap);
      @(negedge clock);
      start <= 0;
      repeat (gap - 1) @(negedge clock);
   endtask

   task drain();
      hold_off(1);
      while (sb.act_q.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task set_rate(logic [15:0] r);
      drain();
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= r;
      @(negedge clock);
      csr_we <= 0;
      sb.rate = r;
   endtask

   function logic signed [15:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return -16'sh8000;
         2: return 0;
         default: return 16'($urandom);
      endcase
   endfunction

   task random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         send(dtl_pkg::OP_LOAD_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15),
              rand_value(), 1'($urandom_range(0, 1)));
      else if (r < 15)
         send(dtl_pkg::OP_LOAD_BIAS, $urandom_range(0, 15), $urandom_range(0, 15),
              rand_value(), 1'($urandom_range(0, 1)));
      else if (r < 30)
         send(dtl_pkg::OP_TARGET, $urandom_range(0, 15), $urandom_range(0, 15),
              rand_value(), 1'($urandom_range(0, 1)));
      else
         send(dtl_pkg::OP_INPUT_ELEM, $urandom_range(0, 15), $urandom_range(0, 15),
              rand_value(), $urandom_range(0, 7) == 0);
   endtask

   initial begin
      logic [15:0] rates [5];
      int burst;
      rates = '{16'hffff, 16'h0000, 16'h0001, 16'h0000, 16'h0000};
      rates[3] = 16'($urandom);
      rates[4] = 16'($urandom);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // target before any forward pass uses the cleared output vector
      for (int n = 0; n < dtl_pkg::NEURONS; n++) begin
         send(dtl_pkg::OP_LOAD_BIAS, n, 0,
              (n == 0) ? -16'sh8000 : (n == 1) ? 16'sh7fff : rand_value(), 0);
         for (int e = 0; e < dtl_pkg::INPUTS; e++)
            send(dtl_pkg::OP_LOAD_WEIGHT, n, e,
                 (n < 2) ? (n == 0 ? 16'sh7fff : -16'sh8000) : rand_value(), 0);
      end
      send(dtl_pkg::OP_TARGET, 0, 0, 16'sh7fff, 0);
      send(dtl_pkg::OP_TARGET, 15, 15, -16'sh8000, 1);
      for (int e = 0; e < dtl_pkg::INPUTS; e++)
         send(dtl_pkg::OP_INPUT_ELEM, 0, e, 16'sh7fff, e == dtl_pkg::INPUTS - 1);
      for (int e = 0; e < dtl_pkg::INPUTS; e++)
         send(dtl_pkg::OP_INPUT_ELEM, 0, e, -16'sh8000, e == dtl_pkg::INPUTS - 1);
      send(dtl_pkg::OP_INPUT_ELEM, 0, 3, 0, 1);
      send(dtl_pkg::OP_TARGET, 2, 0, 16'sh1000, 0);
      send(dtl_pkg::OP_TARGET, 3, 0, -16'sh1000, 0);
      send(dtl_pkg::OP_INPUT_ELEM, 0, 7, 16'sh0400, 1);

      for (int ph = 0; ph < 5; ph++) begin
         set_rate(rates[ph]);
         for (int cnt = 0; cnt < 4; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
               random_item();
               cnt++;
            end
            if ($urandom_range(0, 3) != 0)
               hold_off($urandom_range(1, 20));
         end
      end

      drain();
      repeat (400) @(posedge clock);
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
